@@ hw/rtl/swss_pkg.sv @@
package swss_pkg;

  typedef struct packed {
    logic               op;
    logic [15:0]        dt_us;
    logic               in_water;
    logic               overlaps;
    logic signed [31:0] vertical_speed;
    logic [5:0]         player_segment;
    logic [5:0]         splash_segment;
    logic signed [31:0] splash_speed;
  } in_t;

  typedef struct packed {
    logic [5:0]         segment_number;
    logic signed [31:0] surface_height;
    logic               last_segment;
  } out_t;

  typedef enum logic [2:0] {
    REG_TENSION,
    REG_DAMPING,
    REG_SPREAD,
    REG_ANIM,
    REG_SPLASH,
    REG_COUNT,
    REG_REST
  } reg_idx_t;

  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_SPLASH = 1'b1;

  localparam logic [15:0] SKIP_US      = 16'd33000;
  localparam logic [24:0] LEAVE_FACTOR = 25'd39322;

  // floor(dt * 65536 / 1e6) == (dt * ELAPSED_RECIP) >> 32 for dt < 2^16
  localparam logic [63:0] ELAPSED_RECIP_W = ((64'd1 << 44) + 64'd62499) / 64'd62500;
  localparam logic [28:0] ELAPSED_RECIP   = ELAPSED_RECIP_W[28:0];

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_SPL_MUL,
    ST_SPL_LEAVE,
    ST_SPL_WR,
    ST_SPR_RD,
    ST_SPR_CAP,
    ST_SPR_M1,
    ST_SPR_M2,
    ST_SPR_WB,
    ST_PASS_INIT,
    ST_PASS_HC,
    ST_PAS_RD,
    ST_PAS_CAP,
    ST_R1,
    ST_R2,
    ST_R3,
    ST_L1,
    ST_L2,
    ST_L3,
    ST_PAS_WB,
    ST_OUT_RD,
    ST_OUT_CAP,
    ST_OUT_SEND
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sh000000007FFFFFFF) begin
      return 32'sh7FFFFFFF;
    end else if (v < 64'shFFFFFFFF80000000) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

@@ hw/rtl/swss_ram.sv @@
module swss_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/swss_mul.sv @@
module swss_mul (
  input  logic               clk,
  input  logic signed [41:0] a,
  input  logic signed [24:0] b,
  output logic signed [50:0] q
);

  logic signed [66:0] p;

  assign p = a * b;

  always_ff @(posedge clk) begin
    q <= p[66:16];
  end

endmodule

@@ hw/rtl/spring_water_surface_step_top.sv @@
// Splash request: no result.
// Tick request: each of the n segments is stepped by one shared multiplier;
// skipped with no result when dt_us >= SKIP_US.
// Each result is held until taken; one request at a time.
// Reset clears control and then sweeps all SEGMENTS entries zeroing both
// memories before the first request is accepted.
module spring_water_surface_step_top #(
  parameter int SEGMENTS      = 64,
  parameter int SPREAD_PASSES = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  swss_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output swss_pkg::out_t  out_data,
  input  logic            cfg_we,
  input  logic [2:0]      cfg_index,
  input  logic [31:0]     cfg_data
);
  import swss_pkg::*;

  localparam int IW = $clog2(SEGMENTS);
  localparam int NW = $clog2(SEGMENTS + 1);
  localparam int PW = (SPREAD_PASSES > 1) ? $clog2(SPREAD_PASSES) : 1;

  logic [15:0]        tension;
  logic [15:0]        damping;
  logic [23:0]        spread;
  logic [23:0]        anim_speed;
  logic signed [23:0] splash_gain;
  logic [6:0]         seg_count;
  logic signed [31:0] rest_height;

  state_t state, state_next;
  logic [IW-1:0] j;
  logic [PW-1:0] pass;
  logic          was_in_water;
  logic          water_flag_known;

  in_t                req;
  logic [11:0]        elapsed;
  logic               leaving;
  logic signed [31:0] hp, hc, hn, vc, rdelta;
  logic signed [33:0] m1;

  logic [NW-1:0] n;
  logic          last, first, last_pass, wiw_eff, crossing;
  logic          pseg_ok, sseg_ok;
  logic [44:0]   el_prod;

  logic          h_we, v_we;
  logic [IW-1:0] waddr, h_raddr, v_raddr;
  logic [31:0]   h_wdata, v_wdata, h_rdata, v_rdata;

  logic signed [41:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [50:0] mul_q;

  logic signed [32:0] d_rest, d_left, d_right;
  logic signed [32:0] m2;
  logic signed [35:0] vsum;
  logic signed [31:0] spr_v, spr_h;
  logic signed [31:0] ldelta, h_mid, v_mid, pas_h, pas_v;

  swss_ram #(.DEPTH(SEGMENTS), .AW(IW)) u_heights (
    .clk(clk), .we(h_we), .waddr(waddr), .wdata(h_wdata),
    .raddr(h_raddr), .rdata(h_rdata)
  );

  swss_ram #(.DEPTH(SEGMENTS), .AW(IW)) u_velocities (
    .clk(clk), .we(v_we), .waddr(waddr), .wdata(v_wdata),
    .raddr(v_raddr), .rdata(v_rdata)
  );

  swss_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .q(mul_q));

  always_comb begin
    if (seg_count < 7'd3) begin
      n = NW'(3);
    end else if (32'(seg_count) > SEGMENTS) begin
      n = NW'(SEGMENTS);
    end else begin
      n = NW'(seg_count);
    end
  end

  assign last      = (NW'(j) == n - NW'(1));
  assign first     = (j == '0);
  assign last_pass = (pass == PW'(SPREAD_PASSES - 1));
  assign wiw_eff   = water_flag_known ? was_in_water : req.in_water;
  assign crossing  = (wiw_eff != req.in_water);
  assign pseg_ok   = (32'(req.player_segment) < 32'(n));
  assign sseg_ok   = (32'(req.splash_segment) < 32'(n));
  assign el_prod   = 45'(req.dt_us) * 45'(ELAPSED_RECIP);

  assign d_rest  = 33'(rest_height) - 33'(hc);
  assign d_left  = 33'(hp) - 33'(hc);
  assign d_right = 33'(hn) - 33'(hc);

  assign m2    = mul_q[32:0];
  assign vsum  = 36'(vc) + 36'(m1) - 36'(m2);
  assign spr_v = sat32(64'(vsum));
  assign spr_h = sat32(64'(34'(hc) + 34'(spr_v)));

  assign ldelta = last ? 32'sd0 : sat32(64'(mul_q));
  assign h_mid  = sat32(64'(33'(hc) + 33'(rdelta)));
  assign pas_h  = sat32(64'(33'(h_mid) + 33'(ldelta)));
  assign v_mid  = sat32(64'(33'(vc) + 33'(rdelta)));
  assign pas_v  = sat32(64'(33'(v_mid) + 33'(ldelta)));

  always_ff @(posedge clk) begin
    if (rst) begin
      tension     <= 16'd1638;
      damping     <= 16'd1638;
      spread      <= 24'd65536;
      anim_speed  <= 24'd65536;
      splash_gain <= 24'sd65536;
      seg_count   <= 7'd64;
      rest_height <= 32'sd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TENSION: tension     <= cfg_data[15:0];
        REG_DAMPING: damping     <= cfg_data[15:0];
        REG_SPREAD:  spread      <= cfg_data[23:0];
        REG_ANIM:    anim_speed  <= cfg_data[23:0];
        REG_SPLASH:  splash_gain <= cfg_data[23:0];
        REG_COUNT:   seg_count   <= cfg_data[6:0];
        REG_REST:    rest_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:     if (j == IW'(SEGMENTS - 1)) state_next = ST_IDLE;
      ST_IDLE:      if (in_valid) state_next = ST_DISPATCH;
      ST_DISPATCH: begin
        if (req.op == OP_SPLASH || req.dt_us >= SKIP_US) begin
          state_next = ST_IDLE;
        end else if (crossing && req.overlaps) begin
          state_next = ST_SPL_MUL;
        end else begin
          state_next = ST_SPR_RD;
        end
      end
      ST_SPL_MUL:   state_next = leaving ? ST_SPL_LEAVE : ST_SPL_WR;
      ST_SPL_LEAVE: state_next = ST_SPL_WR;
      ST_SPL_WR:    state_next = ST_SPR_RD;
      ST_SPR_RD:    state_next = ST_SPR_CAP;
      ST_SPR_CAP:   state_next = ST_SPR_M1;
      ST_SPR_M1:    state_next = ST_SPR_M2;
      ST_SPR_M2:    state_next = ST_SPR_WB;
      ST_SPR_WB:    state_next = last ? ST_PASS_INIT : ST_SPR_RD;
      ST_PASS_INIT: state_next = ST_PASS_HC;
      ST_PASS_HC:   state_next = ST_PAS_RD;
      ST_PAS_RD:    state_next = ST_PAS_CAP;
      ST_PAS_CAP:   state_next = ST_R1;
      ST_R1:        state_next = ST_R2;
      ST_R2:        state_next = ST_R3;
      ST_R3:        state_next = ST_L1;
      ST_L1:        state_next = ST_L2;
      ST_L2:        state_next = ST_L3;
      ST_L3:        state_next = ST_PAS_WB;
      ST_PAS_WB: begin
        if (last) begin
          state_next = last_pass ? ST_OUT_RD : ST_PASS_INIT;
        end else begin
          state_next = ST_PAS_RD;
        end
      end
      ST_OUT_RD:    state_next = ST_OUT_CAP;
      ST_OUT_CAP:   state_next = ST_OUT_SEND;
      ST_OUT_SEND:  if (out_ready) state_next = last ? ST_IDLE : ST_OUT_RD;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == ST_IDLE);
    out_valid = (state == ST_OUT_SEND);
    h_we      = 1'b0;
    v_we      = 1'b0;
    waddr     = j;
    h_wdata   = '0;
    v_wdata   = '0;
    h_raddr   = j;
    v_raddr   = j;
    mul_a     = '0;
    mul_b     = '0;
    case (state)
      ST_CLEAR: begin
        h_we = 1'b1;
        v_we = 1'b1;
      end
      ST_DISPATCH: begin
        v_we    = (req.op == OP_SPLASH) && sseg_ok;
        waddr   = IW'(req.splash_segment);
        v_wdata = req.splash_speed;
      end
      ST_SPL_MUL: begin
        mul_a = 42'(req.vertical_speed);
        mul_b = 25'(splash_gain);
      end
      ST_SPL_LEAVE: begin
        mul_a = mul_q[41:0];
        mul_b = LEAVE_FACTOR;
      end
      ST_SPL_WR: begin
        v_we    = pseg_ok;
        waddr   = IW'(req.player_segment);
        v_wdata = sat32(64'(mul_q));
      end
      ST_SPR_M1: begin
        mul_a = 42'(d_rest);
        mul_b = {9'b0, tension};
      end
      ST_SPR_M2: begin
        mul_a = 42'(vc);
        mul_b = {9'b0, damping};
      end
      ST_SPR_WB: begin
        h_we    = 1'b1;
        v_we    = 1'b1;
        h_wdata = spr_h;
        v_wdata = spr_v;
      end
      ST_PASS_INIT: h_raddr = '0;
      ST_PAS_RD:    h_raddr = j + IW'(1);
      ST_R1: begin
        mul_a = 42'(d_left);
        mul_b = {1'b0, spread};
      end
      ST_L1: begin
        mul_a = 42'(d_right);
        mul_b = {1'b0, spread};
      end
      ST_R2, ST_L2: begin
        mul_a = mul_q[41:0];
        mul_b = {13'b0, elapsed};
      end
      ST_R3, ST_L3: begin
        mul_a = mul_q[41:0];
        mul_b = {1'b0, anim_speed};
      end
      ST_PAS_WB: begin
        h_we    = 1'b1;
        v_we    = 1'b1;
        h_wdata = pas_h;
        v_wdata = pas_v;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_CLEAR;
      j                <= '0;
      pass             <= '0;
      was_in_water     <= 1'b0;
      water_flag_known <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_CLEAR: j <= (j == IW'(SEGMENTS - 1)) ? '0 : j + IW'(1);
        ST_DISPATCH: begin
          j    <= '0;
          pass <= '0;
          if (req.op == OP_TICK && req.dt_us < SKIP_US) begin
            was_in_water     <= req.in_water;
            water_flag_known <= 1'b1;
          end
        end
        ST_SPR_WB:    j <= last ? '0 : j + IW'(1);
        ST_PASS_INIT: j <= '0;
        ST_PAS_WB: begin
          j <= last ? '0 : j + IW'(1);
          if (last && !last_pass) pass <= pass + PW'(1);
        end
        ST_OUT_SEND:  if (out_ready) j <= last ? '0 : j + IW'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE:     if (in_valid) req <= in_data;
      ST_DISPATCH: begin
        elapsed <= el_prod[43:32];
        leaving <= wiw_eff;
      end
      ST_SPR_CAP: begin
        hc <= h_rdata;
        vc <= v_rdata;
      end
      ST_SPR_M2:  m1 <= mul_q[33:0];
      ST_PASS_HC: hc <= h_rdata;
      ST_PAS_CAP: begin
        hn <= h_rdata;
        vc <= v_rdata;
      end
      ST_L1:      rdelta <= first ? 32'sd0 : sat32(64'(mul_q));
      ST_PAS_WB: begin
        hp <= hc;
        hc <= hn;
      end
      ST_OUT_CAP: begin
        out_data.segment_number <= 6'(j);
        out_data.surface_height <= h_rdata;
        out_data.last_segment   <= last;
      end
      default: ;
    endcase
  end

endmodule
